/* design/ezvr_pkg.sv */
// ezvr_pkg: shared types, constants and fixed-point helpers for the ZYX vector rotate core.
// Holds the quarter-wave Q1.15 sine table, built at elaboration time.
// No dependencies.
package ezvr_pkg;

	// Table resolution: entries per full turn = 2**SINE_INDEX_BITS (range 6..16)
	localparam int SINE_INDEX_BITS = 10;
	localparam int QSHIFT          = SINE_INDEX_BITS - 2;
	localparam int QUARTER         = 1 << QSHIFT;

	localparam int COMP_W = 16;   // Q3.12 vector component
	localparam int SIN_W  = 16;   // Q1.15 sine / cosine
	localparam int MAT_W  = 17;   // matrix entry, sum of two Q1.15 terms
	localparam int PROD_W = MAT_W + COMP_W;
	localparam int SUM_W  = PROD_W + 2;

	// Cycles from a config register update until the matrix registers hold the new matrix
	localparam int MX_LATENCY = 4;

	// Config register indexes
	localparam logic [1:0] REG_ROLL  = 2'd0;
	localparam logic [1:0] REG_PITCH = 2'd1;
	localparam logic [1:0] REG_YAW   = 2'd2;

	typedef struct packed {
		logic signed [COMP_W-1:0] in_x;
		logic signed [COMP_W-1:0] in_y;
		logic signed [COMP_W-1:0] in_z;
	} vec_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
	} res_t;

	typedef struct packed {
		logic signed [MAT_W-1:0] m00;
		logic signed [MAT_W-1:0] m01;
		logic signed [MAT_W-1:0] m02;
		logic signed [MAT_W-1:0] m10;
		logic signed [MAT_W-1:0] m11;
		logic signed [MAT_W-1:0] m12;
		logic signed [MAT_W-1:0] m20;
		logic signed [MAT_W-1:0] m21;
		logic signed [MAT_W-1:0] m22;
	} mat_t;

	typedef logic signed [SIN_W-1:0] qsin_tab_t [0:QUARTER];

	// pi/2 in unsigned Q62
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] QMASK       = (64'd1 << QSHIFT) - 64'd1;

	// (a * b) >> 62, full-width product
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// floor(num / den), restoring long division; table build only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] q;
		int b;
		rem = '0;
		q = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(32767 * sin(pi/2 * m / QUARTER)), Taylor series in Q62
	function automatic logic signed [SIN_W-1:0] quarter_sine(input logic [63:0] m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] den;
		logic [63:0] r;
		int n;
		x = ((HALF_PI_Q62 >> QSHIFT) * m) + (((HALF_PI_Q62 & QMASK) * m) >> QSHIFT);
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (n = 1; n < 20; n++) begin
			if (term != 64'd0) begin
				den = 64'((2 * n) * (2 * n + 1));
				term = udiv64(mul_q62(term, x2), den);
				if (n[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		r = ((sum >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
		return r[SIN_W-1:0];
	endfunction

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t t;
		int i;
		for (i = 0; i <= QUARTER; i++) begin
			t[i] = quarter_sine(64'(i));
		end
		return t;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();

	// Full-turn sine from the quarter-wave table
	function automatic logic signed [SIN_W-1:0] sine_lookup(input logic [SINE_INDEX_BITS-1:0] k);
		logic [1:0]                 quad;
		logic [SINE_INDEX_BITS-2:0] r;
		logic [SINE_INDEX_BITS-2:0] idx;
		logic signed [SIN_W-1:0]    v;
		quad = k[SINE_INDEX_BITS-1 -: 2];
		r = {1'b0, k[SINE_INDEX_BITS-3:0]};
		idx = quad[0] ? ((SINE_INDEX_BITS-1)'(QUARTER) - r) : r;
		v = QSIN[idx];
		return quad[1] ? -v : v;
	endfunction

	// Q1.15 product, floor shift by 15
	function automatic logic signed [SIN_W-1:0] qmul(input logic signed [SIN_W-1:0] a,
			input logic signed [SIN_W-1:0] b);
		logic signed [2*SIN_W-1:0] p;
		p = a * b;
		return p[2*SIN_W-2:SIN_W-1];
	endfunction

endpackage

/* design/ezvr_matrix.sv */
// ezvr_matrix: four-stage pipeline from the three angle registers to the ZYX rotation matrix.
// Depends on ezvr_pkg (sine table, qmul, mat_t).
module ezvr_matrix (
	input  logic                  clk,
	input  logic [15:0]           roll,
	input  logic [15:0]           pitch,
	input  logic [15:0]           yaw,
	output ezvr_pkg::mat_t        matrix
);

	localparam int B = ezvr_pkg::SINE_INDEX_BITS;
	localparam logic [B-1:0] COS_OFF = B'(ezvr_pkg::QUARTER);

	logic [B-1:0] k_roll, k_pitch, k_yaw;

	// stage 1: table lookups
	logic signed [15:0] s1_s1, c1_s1, s2_s1, c2_s1, s3_s1, c3_s1;
	// stage 2: first products
	logic signed [15:0] c1c2_s2, c1s2_s2, c3s1_s2, s1s3_s2, c1c3_s2;
	logic signed [15:0] s1s2_s2, c2s1_s2, c1s3_s2, c2s3_s2, c2c3_s2;
	logic signed [15:0] s2_s2, s3_s2, c3_s2;
	// stage 3: triple products
	logic signed [15:0] t01_s3, t02_s3, t11_s3, t12_s3;
	logic signed [15:0] c1c2_s3, c3s1_s3, s1s3_s3, c1c3_s3, c1s3_s3;
	logic signed [15:0] c2s1_s3, c2s3_s3, c2c3_s3, s2_s3;
	// stage 4: matrix
	ezvr_pkg::mat_t mat_s4;

	assign k_roll  = roll[15 -: B];
	assign k_pitch = pitch[15 -: B];
	assign k_yaw   = yaw[15 -: B];

	always_ff @(posedge clk) begin
		s1_s1 <= ezvr_pkg::sine_lookup(k_yaw);
		c1_s1 <= ezvr_pkg::sine_lookup(k_yaw + COS_OFF);
		s2_s1 <= ezvr_pkg::sine_lookup(k_pitch);
		c2_s1 <= ezvr_pkg::sine_lookup(k_pitch + COS_OFF);
		s3_s1 <= ezvr_pkg::sine_lookup(k_roll);
		c3_s1 <= ezvr_pkg::sine_lookup(k_roll + COS_OFF);
	end

	always_ff @(posedge clk) begin
		c1c2_s2 <= ezvr_pkg::qmul(c1_s1, c2_s1);
		c1s2_s2 <= ezvr_pkg::qmul(c1_s1, s2_s1);
		c3s1_s2 <= ezvr_pkg::qmul(c3_s1, s1_s1);
		s1s3_s2 <= ezvr_pkg::qmul(s1_s1, s3_s1);
		c1c3_s2 <= ezvr_pkg::qmul(c1_s1, c3_s1);
		s1s2_s2 <= ezvr_pkg::qmul(s1_s1, s2_s1);
		c2s1_s2 <= ezvr_pkg::qmul(c2_s1, s1_s1);
		c1s3_s2 <= ezvr_pkg::qmul(c1_s1, s3_s1);
		c2s3_s2 <= ezvr_pkg::qmul(c2_s1, s3_s1);
		c2c3_s2 <= ezvr_pkg::qmul(c2_s1, c3_s1);
		s2_s2   <= s2_s1;
		s3_s2   <= s3_s1;
		c3_s2   <= c3_s1;
	end

	always_ff @(posedge clk) begin
		t01_s3  <= ezvr_pkg::qmul(c1s2_s2, s3_s2);
		t02_s3  <= ezvr_pkg::qmul(c1s2_s2, c3_s2);
		t11_s3  <= ezvr_pkg::qmul(s1s2_s2, s3_s2);
		t12_s3  <= ezvr_pkg::qmul(c3s1_s2, s2_s2);
		c1c2_s3 <= c1c2_s2;
		c3s1_s3 <= c3s1_s2;
		s1s3_s3 <= s1s3_s2;
		c1c3_s3 <= c1c3_s2;
		c1s3_s3 <= c1s3_s2;
		c2s1_s3 <= c2s1_s2;
		c2s3_s3 <= c2s3_s2;
		c2c3_s3 <= c2c3_s2;
		s2_s3   <= s2_s2;
	end

	always_ff @(posedge clk) begin
		mat_s4.m00 <= 17'(c1c2_s3);
		mat_s4.m01 <= 17'(t01_s3) - 17'(c3s1_s3);
		mat_s4.m02 <= 17'(s1s3_s3) + 17'(t02_s3);
		mat_s4.m10 <= 17'(c2s1_s3);
		mat_s4.m11 <= 17'(c1c3_s3) + 17'(t11_s3);
		mat_s4.m12 <= 17'(t12_s3) - 17'(c1s3_s3);
		mat_s4.m20 <= -17'(s2_s3);
		mat_s4.m21 <= 17'(c2s3_s3);
		mat_s4.m22 <= 17'(c2c3_s3);
	end

	assign matrix = mat_s4;

endmodule

/* design/ezvr_datapath.sv */
// ezvr_datapath: three-stage vector pipeline: capture, nine products, row sums with saturation.
// Depends on ezvr_pkg (vec_t, res_t, mat_t, widths).
module ezvr_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  ezvr_pkg::vec_t        operand,
	input  ezvr_pkg::mat_t        matrix,
	output logic                  done,
	output ezvr_pkg::res_t        result
);

	localparam int CW = ezvr_pkg::COMP_W;
	localparam int MW = ezvr_pkg::MAT_W;
	localparam int PW = ezvr_pkg::PROD_W;
	localparam int SW = ezvr_pkg::SUM_W;
	localparam int RW = SW - 15;
	localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
	localparam logic signed [RW-1:0] SAT_MIN = -RW'(32768);

	logic valid_s1, valid_s2, valid_s3;
	ezvr_pkg::vec_t vec_s1;
	logic signed [PW-1:0] prod_s2 [3][3];
	ezvr_pkg::res_t result_s3;

	logic signed [MW-1:0] coef [3][3];
	logic signed [CW-1:0] comp [3];
	logic signed [SW-1:0] row_sum [3];
	logic signed [RW-1:0] row_shr [3];
	logic signed [CW-1:0] row_sat [3];

	always_comb begin
		coef[0][0] = matrix.m00;
		coef[0][1] = matrix.m01;
		coef[0][2] = matrix.m02;
		coef[1][0] = matrix.m10;
		coef[1][1] = matrix.m11;
		coef[1][2] = matrix.m12;
		coef[2][0] = matrix.m20;
		coef[2][1] = matrix.m21;
		coef[2][2] = matrix.m22;
		comp[0] = vec_s1.in_x;
		comp[1] = vec_s1.in_y;
		comp[2] = vec_s1.in_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_s1 <= operand;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[i][j] <= coef[i][j] * comp[j];
			end
		end
	end

	// floor shift by 15, then clamp to Q3.12
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2]);
			row_shr[i] = row_sum[i][SW-1:15];
			if (row_shr[i] > SAT_MAX) begin
				row_sat[i] = CW'(SAT_MAX);
			end else if (row_shr[i] < SAT_MIN) begin
				row_sat[i] = CW'(SAT_MIN);
			end else begin
				row_sat[i] = row_shr[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result_s3.out_x <= row_sat[0];
		result_s3.out_y <= row_sat[1];
		result_s3.out_z <= row_sat[2];
	end

	assign done   = valid_s3;
	assign result = result_s3;

endmodule

/* design/euler_zyx_vector_rotate_core.sv */
// euler_zyx_vector_rotate_core: top level, rotates Q3.12 3-vectors by the yaw-pitch-roll matrix.
// Depends on ezvr_pkg, ezvr_matrix and ezvr_datapath.
//
//  channel   signals                           transfer when
//  -------   -------------------------------   --------------------------------
//  command   start, busy, operand              start && !busy at rising clk
//  result    done, result                      every cycle done is high (no hold)
//  config    cfg_valid, cfg_ready, cfg_index,  cfg_valid && cfg_ready at rising clk
//            cfg_data
//
// One vector per clock while busy is low; the result passes the capture, product and row-sum stages.
// Matrix is rebuilt by a 4-stage pipeline off the angle registers; after reset
// and after each config write busy stays high while the settle counter runs down.
// Outside that window busy is low and the block takes a vector every cycle.
// The result side cannot stall: each result is shown for exactly one cycle with done high.
// arst_n clears the angle registers and the valid bits and loads the settle counter.
module euler_zyx_vector_rotate_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ezvr_pkg::vec_t        operand,
	output logic                  done,
	output ezvr_pkg::res_t        result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam logic [2:0] SETTLE_CYCLES = 3'(ezvr_pkg::MX_LATENCY);

	logic [15:0] roll_q, pitch_q, yaw_q;
	logic [2:0]  settle_q;
	logic        cfg_write;
	logic        accept;
	ezvr_pkg::mat_t matrix;

	// config port never back-pressures
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign busy      = (settle_q != 3'd0);
	assign accept    = start && !busy;

	// angle registers; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q  <= 16'd0;
			pitch_q <= 16'd0;
			yaw_q   <= 16'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				ezvr_pkg::REG_ROLL: begin
					roll_q <= cfg_data;
				end
				ezvr_pkg::REG_PITCH: begin
					pitch_q <= cfg_data;
				end
				ezvr_pkg::REG_YAW: begin
					yaw_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// settle counter: covers the matrix pipeline after reset or any config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_write) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	ezvr_matrix u_matrix (
		.clk    (clk),
		.roll   (roll_q),
		.pitch  (pitch_q),
		.yaw    (yaw_q),
		.matrix (matrix)
	);

	ezvr_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.operand (operand),
		.matrix  (matrix),
		.done    (done),
		.result  (result)
	);

	// every command transfer yields a result strobe once it has passed the datapath stages
	a_cmd_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result strobe missing after command transfer");

	// no result strobe without a matching earlier command transfer
	a_done_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result strobe without matching command");

	// angle change must hold off commands while the matrix settles
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> busy)
		else $error("busy low right after config write");

endmodule
